[hdl/triangle_face_normal_assert.svh]
// Assertion macros used by the top level of the face normal pipeline.
`ifndef TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ASSERT_SVH

// Implication checked at every rising clock edge, off while reset is applied.
`define TFN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is applied.
`define TFN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/tfn_pkg.sv]
package tfn_pkg;

	localparam int COORD_BITS       = 16;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int EDGE_BITS        = COORD_BITS + 1;
	localparam int PROD_BITS        = 2 * EDGE_BITS;
	localparam int CROSS_BITS       = PROD_BITS + 1;
	localparam int MAG_BITS         = PROD_BITS;
	localparam int SQ_BITS          = 2 * MAG_BITS;
	localparam int NORM_BITS        = SQ_BITS + 2;
	localparam int SQRT_STEPS       = NORM_BITS / 2;
	localparam int LEN_BITS         = SQRT_STEPS;
	localparam int REM_BITS         = LEN_BITS + 1;
	localparam int OUT_BITS         = NORMAL_FRAC_BITS + 2;
	localparam int QUO_BITS         = NORMAL_FRAC_BITS + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [CROSS_BITS-1:0] cross_t;
	typedef logic signed [OUT_BITS-1:0]   normal_t;
	typedef logic [LEN_BITS-1:0]          len_t;

	typedef struct packed {
		cross_t x;
		cross_t y;
		cross_t z;
	} cross3_t;

	// Partial state of the digit-by-digit square root.
	typedef struct packed {
		logic [NORM_BITS-1:0] rem;
		logic [NORM_BITS-1:0] res;
	} sqrt_t;

	// Partial state of the restoring division of one component.
	typedef struct packed {
		logic [REM_BITS-1:0] rem;
		logic [QUO_BITS-1:0] quo;
	} div_t;

	function automatic sqrt_t sqrt_step(sqrt_t cur, int unsigned shift);
		logic [NORM_BITS-1:0] one;
		logic [NORM_BITS-1:0] trial;
		sqrt_t nxt;
		one   = {{(NORM_BITS-1){1'b0}}, 1'b1} << shift;
		trial = cur.res + one;
		if (cur.rem >= trial) begin
			nxt.rem = cur.rem - trial;
			nxt.res = (cur.res >> 1) + one;
		end else begin
			nxt.rem = cur.rem;
			nxt.res = cur.res >> 1;
		end
		return nxt;
	endfunction

	function automatic div_t div_step(div_t cur, len_t len);
		logic [REM_BITS-1:0] r2;
		logic [REM_BITS-1:0] dl;
		div_t nxt;
		r2 = {cur.rem[REM_BITS-2:0], 1'b0};
		dl = {1'b0, len};
		if (r2 >= dl) begin
			nxt.rem = r2 - dl;
			nxt.quo = {cur.quo[QUO_BITS-2:0], 1'b1};
		end else begin
			nxt.rem = r2;
			nxt.quo = {cur.quo[QUO_BITS-2:0], 1'b0};
		end
		return nxt;
	endfunction

	function automatic logic [MAG_BITS-1:0] mag_of(cross_t v);
		cross_t a;
		a = v[CROSS_BITS-1] ? -v : v;
		return a[MAG_BITS-1:0];
	endfunction

endpackage

[hdl/tfn_cross.sv]
module tfn_cross (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_in,
	input  tfn_pkg::coord_t ax, ay, az, bx, by, bz, cx, cy, cz,
	output logic            vld_out,
	output tfn_pkg::cross3_t p_out
);
	import tfn_pkg::*;

	typedef logic signed [EDGE_BITS-1:0] edge_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;

	logic  vld_s1, vld_s2, vld_s3;
	edge_t e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;
	prod_t yz_s2, zy_s2, zx_s2, xz_s2, xy_s2, yx_s2;
	cross3_t p_s3;

	function automatic edge_t diff(coord_t hi, coord_t lo);
		return edge_t'({hi[COORD_BITS-1], hi}) - edge_t'({lo[COORD_BITS-1], lo});
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1x_s1 <= diff(bx, ax);
			e1y_s1 <= diff(by, ay);
			e1z_s1 <= diff(bz, az);
			e2x_s1 <= diff(cx, ax);
			e2y_s1 <= diff(cy, ay);
			e2z_s1 <= diff(cz, az);
			yz_s2  <= e1y_s1 * e2z_s1;
			zy_s2  <= e1z_s1 * e2y_s1;
			zx_s2  <= e1z_s1 * e2x_s1;
			xz_s2  <= e1x_s1 * e2z_s1;
			xy_s2  <= e1x_s1 * e2y_s1;
			yx_s2  <= e1y_s1 * e2x_s1;
			p_s3.x <= cross_t'({yz_s2[PROD_BITS-1], yz_s2}) - cross_t'({zy_s2[PROD_BITS-1], zy_s2});
			p_s3.y <= cross_t'({zx_s2[PROD_BITS-1], zx_s2}) - cross_t'({xz_s2[PROD_BITS-1], xz_s2});
			p_s3.z <= cross_t'({xy_s2[PROD_BITS-1], xy_s2}) - cross_t'({yx_s2[PROD_BITS-1], yx_s2});
		end
	end

	assign vld_out = vld_s3;
	assign p_out   = p_s3;

endmodule

[hdl/tfn_sqrt.sv]
module tfn_sqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  tfn_pkg::cross3_t p_in,
	output logic             vld_out,
	output tfn_pkg::cross3_t p_out,
	output tfn_pkg::len_t    len_out
);
	import tfn_pkg::*;

	logic                vld_s1;
	logic [SQ_BITS-1:0]  sqx_s1, sqy_s1, sqz_s1;
	cross3_t             p_s1;
	logic                vld_s [SQRT_STEPS+1];
	sqrt_t               st_s  [SQRT_STEPS+1];
	cross3_t             p_s   [SQRT_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int i = 0; i <= SQRT_STEPS; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s1   <= vld_in;
			vld_s[0] <= vld_s1;
			for (int i = 0; i < SQRT_STEPS; i++) vld_s[i+1] <= vld_s[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1      <= mag_of(p_in.x) * mag_of(p_in.x);
			sqy_s1      <= mag_of(p_in.y) * mag_of(p_in.y);
			sqz_s1      <= mag_of(p_in.z) * mag_of(p_in.z);
			p_s1        <= p_in;
			st_s[0].rem <= {2'b00, sqx_s1} + {2'b00, sqy_s1} + {2'b00, sqz_s1};
			st_s[0].res <= '0;
			p_s[0]      <= p_s1;
			// One result bit per stage, most significant first.
			for (int i = 0; i < SQRT_STEPS; i++) begin
				st_s[i+1] <= sqrt_step(st_s[i], 2 * (SQRT_STEPS - 1 - i));
				p_s[i+1]  <= p_s[i];
			end
		end
	end

	assign vld_out = vld_s[SQRT_STEPS];
	assign p_out   = p_s[SQRT_STEPS];
	assign len_out = st_s[SQRT_STEPS].res[LEN_BITS-1:0];

endmodule

[hdl/tfn_div.sv]
module tfn_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  tfn_pkg::cross3_t p_in,
	input  tfn_pkg::len_t    len_in,
	output logic             vld_out,
	output tfn_pkg::normal_t nx,
	output tfn_pkg::normal_t ny,
	output tfn_pkg::normal_t nz,
	output logic             degenerate
);
	import tfn_pkg::*;

	localparam int STEPS = NORMAL_FRAC_BITS;

	logic       vld_s [STEPS+1];
	div_t       dv_s  [STEPS+1][3];
	len_t       len_s [STEPS+1];
	logic [2:0] neg_s [STEPS+1];
	logic       dgn_s [STEPS+1];
	logic       vld_o_s;
	normal_t    n_o_s [3];
	logic       dgn_o_s;

	logic [MAG_BITS-1:0] m_in [3];
	assign m_in[0] = mag_of(p_in.x);
	assign m_in[1] = mag_of(p_in.y);
	assign m_in[2] = mag_of(p_in.z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= STEPS; i++) vld_s[i] <= 1'b0;
			vld_o_s <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
			for (int i = 0; i < STEPS; i++) vld_s[i+1] <= vld_s[i];
			vld_o_s <= vld_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// The magnitude never exceeds the length, so the integer quotient is 0 or 1.
			for (int k = 0; k < 3; k++) begin
				if ({{(LEN_BITS-MAG_BITS){1'b0}}, m_in[k]} >= len_in) begin
					dv_s[0][k].quo <= QUO_BITS'(1);
					dv_s[0][k].rem <= REM_BITS'(m_in[k]) - REM_BITS'(len_in);
				end else begin
					dv_s[0][k].quo <= '0;
					dv_s[0][k].rem <= REM_BITS'(m_in[k]);
				end
			end
			len_s[0] <= len_in;
			neg_s[0] <= {p_in.z[CROSS_BITS-1], p_in.y[CROSS_BITS-1], p_in.x[CROSS_BITS-1]};
			dgn_s[0] <= (len_in == '0);
			for (int i = 0; i < STEPS; i++) begin
				for (int k = 0; k < 3; k++) dv_s[i+1][k] <= div_step(dv_s[i][k], len_s[i]);
				len_s[i+1] <= len_s[i];
				neg_s[i+1] <= neg_s[i];
				dgn_s[i+1] <= dgn_s[i];
			end
			for (int k = 0; k < 3; k++) begin
				if (dgn_s[STEPS]) begin
					n_o_s[k] <= '0;
				end else if (neg_s[STEPS][k]) begin
					n_o_s[k] <= -normal_t'({1'b0, dv_s[STEPS][k].quo});
				end else begin
					n_o_s[k] <= normal_t'({1'b0, dv_s[STEPS][k].quo});
				end
			end
			dgn_o_s <= dgn_s[STEPS];
		end
	end

	assign vld_out    = vld_o_s;
	assign nx         = n_o_s[0];
	assign ny         = n_o_s[1];
	assign nz         = n_o_s[2];
	assign degenerate = dgn_o_s;

endmodule

[hdl/triangle_face_normal.sv]
// Unit face normal of a triangle, streamed one triangle per clock unless stalled.
// The request channel carries the nine vertex coordinates (ax..cz) under
// in_valid / in_stall; a request is taken on a rising edge where in_valid is
// high and in_stall is low. The result channel carries nx, ny, nz in signed
// Q1.14 plus the degenerate flag under out_valid / out_stall.
// Between acceptance and the result being shown lie the register stages for
// edges and cross product, for squares and their sum, for the square root
// (one result bit per stage, set by the 70-bit squared norm), and for the
// three parallel restoring dividers (integer step plus 14 fraction steps)
// and the output register.
// Throughput is one triangle per cycle while no valid result is stalled; every stage is a register slice.
// Reset clears all valid bits, so the pipeline comes up empty; data registers
// are not reset. When the receiver stalls a valid result, the whole pipeline
// freezes and in_stall rises in the same cycle, so nothing is lost or
// repeated; bubbles in the pipeline are not squeezed out while stalled.
// A triangle whose cross product is zero gives a zero normal with degenerate set.
module triangle_face_normal (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  tfn_pkg::coord_t  ax, ay, az, bx, by, bz, cx, cy, cz,
	output logic             out_valid,
	input  logic             out_stall,
	output tfn_pkg::normal_t nx,
	output tfn_pkg::normal_t ny,
	output tfn_pkg::normal_t nz,
	output logic             degenerate
);
	import tfn_pkg::*;

	`include "triangle_face_normal_assert.svh"

	// The pipeline advances unless a valid result is being held back.
	logic    en;
	logic    vld_c, vld_r;
	cross3_t p_c, p_r;
	len_t    len_r;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	tfn_cross u_cross (
		.clk, .arst_n, .en,
		.vld_in (in_valid && !in_stall),
		.ax, .ay, .az, .bx, .by, .bz, .cx, .cy, .cz,
		.vld_out(vld_c),
		.p_out  (p_c)
	);

	tfn_sqrt u_sqrt (
		.clk, .arst_n, .en,
		.vld_in (vld_c),
		.p_in   (p_c),
		.vld_out(vld_r),
		.p_out  (p_r),
		.len_out(len_r)
	);

	tfn_div u_div (
		.clk, .arst_n, .en,
		.vld_in    (vld_r),
		.p_in      (p_r),
		.len_in    (len_r),
		.vld_out   (out_valid),
		.nx, .ny, .nz,
		.degenerate
	);

	localparam normal_t ONE_Q = normal_t'(1) <<< NORMAL_FRAC_BITS;

	`TFN_ASSERT_IMP(a_stall_follows_out, clk, arst_n, 1'b1, in_stall == (out_valid && out_stall), "input stall does not track output backpressure")
	`TFN_ASSERT_IMP(a_degen_zero, clk, arst_n, out_valid && degenerate, nx == '0 && ny == '0 && nz == '0, "degenerate result with nonzero normal")
	`TFN_ASSERT_IMP(a_range, clk, arst_n, out_valid, nx <= ONE_Q && nx >= -ONE_Q && ny <= ONE_Q && ny >= -ONE_Q && nz <= ONE_Q && nz >= -ONE_Q, "normal component out of range")
	`TFN_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(nx) && $stable(degenerate), "stalled result changed")

endmodule
